### src/assert_macros.svh
// Assertion macros used by the checker file of the allocator.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked and disabled during reset.
`define GHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define GHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gha_pkg.sv
// Package of the generational handle allocator: sizes, codes and types.
// No dependencies.
`default_nettype none

package gha_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = 10;
    localparam int GEN_W     = 32;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int STATUS_W  = 2;

    localparam logic OP_CREATE  = 1'b0;
    localparam logic OP_DESTROY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
        logic [GEN_W-1:0]    slot_gen;
    } rsp_t;

endpackage

`default_nettype wire

### src/gha_req_if.sv
// Request channel of the allocator: valid/ready plus opcode and handle.
// Depends on gha_pkg.
`default_nettype none

interface gha_req_if;

    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [gha_pkg::IDX_W-1:0] handle_index;
    logic [gha_pkg::GEN_W-1:0] handle_gen;

    modport source (output valid, output opcode, output handle_index, output handle_gen,
                    input ready);
    modport sink   (input valid, input opcode, input handle_index, input handle_gen,
                    output ready);

endinterface

`default_nettype wire

### src/gha_rsp_if.sv
// Result channel of the allocator: valid/ready plus status and new handle.
// Depends on gha_pkg.
`default_nettype none

interface gha_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [gha_pkg::STATUS_W-1:0] status;
    logic [gha_pkg::IDX_W-1:0]    slot_index;
    logic [gha_pkg::GEN_W-1:0]    slot_gen;

    modport source (output valid, output status, output slot_index, output slot_gen,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input slot_gen,
                    output ready);

endinterface

`default_nettype wire

### src/gha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/generational_handle_allocator.sv
// Generational handle allocator: create/destroy of handles over a slot table.
// Depends on gha_pkg, gha_req_if, gha_rsp_if and gha_ram.
//
//  channel | dir | fields                               | transfer
//  --------+-----+--------------------------------------+-------------------
//  req     | in  | opcode, handle_index, handle_gen     | valid && ready
//  rsp     | out | status, slot_index, slot_gen         | valid && ready
//
// One request at a time. Fresh create, full table and rejected destroy finish in the idle state.
// Checked destroy: generation RAM read, then write-back and push.
// Create from the free stack: stack RAM read, generation RAM read, finish.
// Reset clears the stack depth and used-slot count; RAMs need no clearing.
// A result waits in the output register; the next request is taken meanwhile
// and only its finish stalls while the output register is still occupied.
`default_nettype none

module generational_handle_allocator (
    input wire logic clk,
    input wire logic rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    import gha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_GEN  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [GEN_W-1:0] hgen_reg, hgen_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg;
    logic             out_valid_reg;

    logic             req_fire;
    logic             out_free;
    logic             fin;
    rsp_t             res;
    logic [CNT_W-1:0] depth_m1;
    logic [GEN_W-1:0] gen_bump;

    logic             gen_we;
    logic [IDX_W-1:0] gen_waddr;
    logic [GEN_W-1:0] gen_wdata;
    logic [IDX_W-1:0] gen_raddr;
    logic [GEN_W-1:0] gen_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    logic [IDX_W-1:0] stk_wdata;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_rdata;

    gha_ram #(.WIDTH(GEN_W), .DEPTH(MAX_SLOTS)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign depth_m1   = depth_reg - CNT_W'(1);
    assign gen_bump   = (gen_rdata == '1) ? GEN_ONE : gen_rdata + GEN_ONE;

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.slot_index = out_reg.slot_index;
    assign rsp.slot_gen   = out_reg.slot_gen;

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        hgen_next  = hgen_reg;
        slot_next  = slot_reg;
        res_next   = res_reg;
        fin        = 1'b0;
        res        = '{status: ST_DONE, slot_index: '0, slot_gen: '0};
        gen_we     = 1'b0;
        gen_waddr  = idx_reg;
        gen_wdata  = gen_bump;
        gen_raddr  = req.handle_index;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[IDX_W-1:0];
        stk_wdata  = idx_reg;
        stk_raddr  = depth_m1[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    idx_next  = req.handle_index;
                    hgen_next = req.handle_gen;
                    if (req.opcode == OP_CREATE)
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_next = depth_m1;
                            state_next = S_POP;
                        end
                        else if (used_reg < CNT_W'(MAX_SLOTS))
                        begin
                            gen_we     = 1'b1;
                            gen_waddr  = used_reg[IDX_W-1:0];
                            gen_wdata  = GEN_ONE;
                            used_next  = used_reg + CNT_W'(1);
                            fin        = 1'b1;
                            res        = '{status: ST_DONE, slot_index: used_reg[IDX_W-1:0],
                                           slot_gen: GEN_ONE};
                        end
                        else
                        begin
                            fin = 1'b1;
                            res = '{status: ST_FULL, slot_index: '0, slot_gen: '0};
                        end
                    end
                    else
                    begin
                        if (req.handle_gen == '0 ||
                            CNT_W'(req.handle_index) >= used_reg ||
                            depth_reg >= CNT_W'(MAX_SLOTS))
                        begin
                            fin = 1'b1;
                            res = '{status: ST_BAD, slot_index: '0, slot_gen: '0};
                        end
                        else
                        begin
                            state_next = S_CHK;
                        end
                    end
                end
            end
            S_POP:
            begin
                slot_next  = stk_rdata;
                gen_raddr  = stk_rdata;
                state_next = S_GEN;
            end
            S_GEN:
            begin
                fin = 1'b1;
                if (gen_rdata == '0)
                begin
                    gen_we    = 1'b1;
                    gen_waddr = slot_reg;
                    gen_wdata = GEN_ONE;
                    res       = '{status: ST_DONE, slot_index: slot_reg, slot_gen: GEN_ONE};
                end
                else
                begin
                    res = '{status: ST_DONE, slot_index: slot_reg, slot_gen: gen_rdata};
                end
            end
            S_CHK:
            begin
                fin = 1'b1;
                if (gen_rdata != hgen_reg)
                begin
                    res = '{status: ST_BAD, slot_index: '0, slot_gen: '0};
                end
                else
                begin
                    gen_we     = 1'b1;
                    stk_we     = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_WAIT;
                res_next   = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            used_reg  <= used_next;
            if ((fin && out_free) || (state_reg == S_WAIT && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        hgen_reg <= hgen_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
        if (fin && out_free)
        begin
            out_reg <= res;
        end
        else if (state_reg == S_WAIT && out_free)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

### src/gha_checker.sv
// Port-level checker of the allocator, bound to the top level.
// Depends on gha_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gha_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic [gha_pkg::STATUS_W-1:0] rsp_status,
    input wire logic [gha_pkg::IDX_W-1:0]    rsp_slot_index,
    input wire logic [gha_pkg::GEN_W-1:0]    rsp_slot_gen
);

    import gha_pkg::*;

    logic                                  rsp_stall;
    logic                                  rsp_fail;
    logic                                  rsp_null;
    logic                                  rsp_idx0;
    logic                                  rsp_zero;
    logic [STATUS_W+IDX_W+GEN_W:0]         rsp_word;

    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_fail  = rsp_valid && rsp_status != ST_DONE;
    assign rsp_null  = rsp_valid && rsp_slot_gen == '0;
    assign rsp_idx0  = rsp_slot_index == '0;
    assign rsp_zero  = rsp_idx0 && rsp_slot_gen == '0;
    assign rsp_word  = {rsp_valid, rsp_status, rsp_slot_index, rsp_slot_gen};

    `GHA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stall, $stable(rsp_word), "result not held")
    `GHA_ASSERT_IMP(a_status_code, clk, rst_n, rsp_valid, rsp_status <= ST_BAD, "bad status")
    `GHA_ASSERT_IMP(a_fail_zero, clk, rst_n, rsp_fail, rsp_zero, "failure returned a handle")
    `GHA_ASSERT_IMP(a_null_gen, clk, rst_n, rsp_null, rsp_idx0, "null handle with index")

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_slot_index (rsp.slot_index),
    .rsp_slot_gen   (rsp.slot_gen)
);

`default_nettype wire

### tb/tb_generational_handle_allocator.sv
// Self-checking testbench for generational_handle_allocator: directed and random
// create/destroy traffic, scored against a cycle-free predictor of the slot table.
// Depends on gha_pkg, gha_req_if, gha_rsp_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_generational_handle_allocator;

    import gha_pkg::*;

    typedef enum int {MIXED, GROW, SHRINK} phase_t;

    class handle_sb_t;
        logic [GEN_W-1:0] gen_table [MAX_SLOTS];
        logic [IDX_W-1:0] free_stack [MAX_SLOTS];
        int unsigned      free_depth;
        int unsigned      slots_used;
        rsp_t             pending_results [$];
        int               failures;
        int               full_hits;
        int               overflow_hits;

        function new();
            free_depth    = 0;
            slots_used    = 0;
            failures      = 0;
            full_hits     = 0;
            overflow_hits = 0;
        endfunction

        function void note_request(logic op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
            rsp_t             r;
            logic [IDX_W-1:0] slot;
            logic [GEN_W-1:0] g;
            r.status     = ST_DONE;
            r.slot_index = '0;
            r.slot_gen   = '0;
            if (op == OP_CREATE)
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot = free_stack[free_depth];
                    g    = gen_table[slot];
                    if (g == '0)
                    begin
                        g               = GEN_ONE;
                        gen_table[slot] = g;
                    end
                    r.slot_index = slot;
                    r.slot_gen   = g;
                end
                else if (slots_used < MAX_SLOTS)
                begin
                    slot = IDX_W'(slots_used);
                    slots_used++;
                    gen_table[slot] = GEN_ONE;
                    r.slot_index    = slot;
                    r.slot_gen      = GEN_ONE;
                end
                else
                begin
                    r.status = ST_FULL;
                    full_hits++;
                end
            end
            else
            begin
                if (gen == '0 || idx >= slots_used || gen_table[idx] != gen)
                    r.status = ST_BAD;
                else if (free_depth >= MAX_SLOTS)
                begin
                    r.status = ST_BAD;
                    overflow_hits++;
                end
                else
                begin
                    g = gen + GEN_ONE;
                    if (g == '0)
                        g = GEN_ONE;
                    gen_table[idx]         = g;
                    free_stack[free_depth] = idx;
                    free_depth++;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: status %0d index %0d gen %0h",
                             got.status, got.slot_index, got.slot_gen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.slot_index !== want.slot_index ||
                    got.slot_gen !== want.slot_gen)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: exp st %0d idx %0d gen %0h, got st %0d idx %0d gen %0h",
                                 want.status, want.slot_index, want.slot_gen,
                                 got.status, got.slot_index, got.slot_gen);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet;

    gha_req_if req_ch ();
    gha_rsp_if rsp_ch ();

    handle_sb_t sb;

    generational_handle_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // result side: random stalls on ready
    initial
    begin
        int stall;
        stall        = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                stall        = pick_gap();
            end
        end
    end

    // check results before noting the request of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_t'({rsp_ch.status, rsp_ch.slot_index, rsp_ch.slot_gen}));
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.opcode, req_ch.handle_index, req_ch.handle_gen);
        end
    end

    task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.opcode       = op;
        req_ch.handle_index = idx;
        req_ch.handle_gen   = gen;
        req_ch.valid        = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(phase_t phase);
        int               r;
        int               kind;
        int               p_create;
        int               p_valid;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        case (phase)
            GROW:    begin p_create = 92; p_valid = 95; end
            SHRINK:  begin p_create = 3;  p_valid = 95; end
            default: begin p_create = 45; p_valid = 85; end
        endcase
        r   = $urandom_range(0, 99);
        idx = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
        gen = $urandom;
        if (r < p_create || (r < p_valid && sb.slots_used == 0))
            send_request(OP_CREATE, idx, gen);
        else if (r < p_valid)
        begin
            idx = IDX_W'($urandom_range(0, sb.slots_used - 1));
            send_request(OP_DESTROY, idx, sb.gen_table[idx]);
        end
        else
        begin
            kind = $urandom_range(0, 3);
            if (kind == 0)
                gen = '0;
            else if (kind == 1 && sb.slots_used > 0)
            begin
                idx = IDX_W'($urandom_range(0, sb.slots_used - 1));
                if ($urandom_range(0, 1))
                    gen = sb.gen_table[idx] + GEN_W'($urandom_range(1, 3));
                else
                    gen = sb.gen_table[idx] - GEN_W'($urandom_range(1, 3));
            end
            else if (kind == 3 && sb.slots_used < MAX_SLOTS)
                idx = IDX_W'($urandom_range(sb.slots_used, MAX_SLOTS - 1));
            send_request(OP_DESTROY, idx, gen);
        end
    endtask

    task automatic run_phase(phase_t phase, int max_items);
        int n;
        int full_goal;
        int overflow_goal;
        full_goal     = sb.full_hits + 4;
        overflow_goal = sb.overflow_hits + 4;
        for (n = 0; n < max_items; n++)
        begin
            if (phase == GROW && sb.full_hits >= full_goal)
                break;
            if (phase == SHRINK && sb.overflow_hits >= overflow_goal)
                break;
            if (n % 64 == 0)
                quiet = ($urandom_range(0, 4) == 0);
            send_random(phase);
        end
        quiet = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb                  = new();
        quiet               = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_CREATE;
        req_ch.handle_index = '0;
        req_ch.handle_gen   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: range checks on an empty table, null and stale handles,
        // forged destroy of a free slot, LIFO reuse, ignored create fields
        send_request(OP_DESTROY, 10'd0, 32'd1);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_DESTROY, 10'd0, 32'd0);
        send_request(OP_DESTROY, 10'd1023, 32'hFFFF_FFFF);
        send_request(OP_DESTROY, 10'd2, 32'd1);
        send_request(OP_DESTROY, 10'd0, 32'd2);
        send_request(OP_DESTROY, 10'd0, 32'hFFFF_FFFF);
        send_request(OP_DESTROY, 10'd0, 32'd1);
        send_request(OP_DESTROY, 10'd0, 32'd2);
        send_request(OP_DESTROY, 10'd1, 32'd1);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_CREATE, 10'd0, 32'd0);
        send_request(OP_CREATE, 10'd1023, 32'hFFFF_FFFF);
        send_request(OP_DESTROY, 10'd0, 32'd3);
        send_request(OP_DESTROY, 10'd0, 32'd3);
        send_request(OP_DESTROY, 10'd3, 32'd0);

        run_phase(MIXED, 150);
        req_ch.valid = 1'b0;
        wait_drained();
        @(negedge clk);
        // fill the table, then free a good part of it
        run_phase(GROW, 2000);
        run_phase(SHRINK, 250);
        run_phase(MIXED, 80);
        req_ch.valid = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("tb_generational_handle_allocator passed");
        else
            $display("tb_generational_handle_allocator failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_generational_handle_allocator failed");
        $finish;
    end

endmodule
